FILE: rtl/tsf_pkg.sv
// Shared types, constants and fixed-point helpers for the trend smoothing forecaster.
`timescale 1ns / 1ps
`default_nettype none

package tsf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int Q_W         = 24;
  localparam int W_W         = 17;
  localparam int SUM_W       = 48;
  localparam int MUL_W       = 26;
  localparam int PROD_W      = 2 * MUL_W;
  localparam int WIDE        = ((SAMPLE_BITS > MUL_W) ? SAMPLE_BITS : MUL_W) + 2;
  localparam int FRAC_W      = 16;

  localparam logic [W_W-1:0] ONE_Q16 = W_W'(65536);

  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_BETA  = 1'b1;

  localparam logic [1:0] PH_EMPTY = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  typedef struct packed {
    logic                  clip;
    logic signed [Q_W-1:0] val;
  } sat_t;

  function automatic sat_t sat24(input logic signed [WIDE-1:0] v);
    sat_t r;
    logic signed [WIDE-1:0] qmax;
    logic signed [WIDE-1:0] qmin;
    qmax = WIDE'(signed'({1'b0, {(Q_W-1){1'b1}}}));
    qmin = -qmax - WIDE'(1);
    if (v > qmax) begin
      r.clip = 1'b1;
      r.val  = qmax[Q_W-1:0];
    end else if (v < qmin) begin
      r.clip = 1'b1;
      r.val  = qmin[Q_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [WIDE-1:0] ext24(input logic signed [Q_W-1:0] v);
    return {{(WIDE-Q_W){v[Q_W-1]}}, v};
  endfunction

  function automatic logic signed [MUL_W-1:0] weight_op(input logic [W_W-1:0] w);
    logic [W_W-1:0] c;
    c = (w > ONE_Q16) ? ONE_Q16 : w;
    return {{(MUL_W-W_W){1'b0}}, c};
  endfunction

  // round to nearest, ties up: floor((p + 2^15) / 2^16)
  function automatic logic signed [WIDE-1:0] round16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return t[WIDE+FRAC_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tsf_mul.sv
// Shared signed multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module tsf_mul
  import tsf_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic signed [MUL_W-1:0]  a_i,
  input  wire logic signed [MUL_W-1:0]  b_i,
  output logic signed [PROD_W-1:0]      p_o
);

  logic signed [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

FILE: rtl/trend_smoothing_forecaster_core.sv
// Top level: level/trend exponential smoothing sequencer around one shared multiplier.
//
// Input channel (in_valid_i/in_ready_o) carries restart_i and a signed Q8.8
// sample_i; output channel (out_valid_o/out_ready_i) carries one result per
// input transfer. alpha/beta go in through cfg_we_i/cfg_index_i/cfg_wdata_i;
// the user writes them only while the block is idle; the block does not enforce it.
// A first sample of a series (or restart) goes straight to the output
// register, a second sample through the forecast step first, and every
// later sample through error square, level weighting and trend weighting,
// one after another through the single registered multiplier.
// in_ready_o is high only while the sequencer is idle, so one item is in
// work at a time. The result sits in an output register; the next item is
// taken while it waits, but finishes only once that register is free.
// Reset clears the series state, the error sum and the output valid, and
// sets both weights to one half.
`timescale 1ns / 1ps
`default_nettype none

module trend_smoothing_forecaster_core
  import tsf_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic                          cfg_index_i,
  input  wire logic [W_W-1:0]                cfg_wdata_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          restart_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               forecast_valid_o,
  output logic signed [Q_W-1:0]              forecast_o,
  output logic                               error_valid_o,
  output logic signed [Q_W-1:0]              error_o,
  output logic signed [Q_W-1:0]              level_o,
  output logic signed [Q_W-1:0]              trend_o,
  output logic [SUM_W-1:0]                   sum_sq_error_o,
  output logic                               saturated_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_LVL, S_NLV, S_TRM, S_TRD, S_PF, S_OUT
  } state_e;

  state_e state_q;

  logic [W_W-1:0]        alpha_q, beta_q;
  logic [1:0]            phase_q;
  logic signed [Q_W-1:0] x_q, prev_q, level_q, trend_q, pf_q, err_q, nl_q;
  logic [SUM_W-1:0]      sum_q;
  logic                  clip_q, fv_q, ev_q;

  logic                  out_valid_q, fvo_q, evo_q, sato_q;
  logic signed [Q_W-1:0] fco_q, erro_q, lvlo_q, trdo_q;
  logic [SUM_W-1:0]      sumo_q;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [WIDE-1:0]   x_ext, diff_w;
  sat_t                     xs, trs, ers, nls, tns, pfs;
  logic [SUM_W:0]           sum_add;

  tsf_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  assign x_ext = {{(WIDE-SAMPLE_BITS){sample_i[SAMPLE_BITS-1]}}, sample_i};
  assign xs    = sat24(x_ext);
  assign trs   = sat24(ext24(xs.val) - ext24(prev_q));
  assign ers   = sat24(ext24(pf_q) - ext24(xs.val));
  assign nls   = sat24(ext24(pf_q) + round16(prod));
  assign tns   = sat24(ext24(trend_q) + round16(prod));
  assign pfs   = sat24(ext24(level_q) + ext24(trend_q));
  assign sum_add = {1'b0, sum_q} + {1'b0, prod[SUM_W-1:0]};

  always_comb begin
    mul_a  = {{(MUL_W-Q_W){err_q[Q_W-1]}}, err_q};
    mul_b  = {{(MUL_W-Q_W){err_q[Q_W-1]}}, err_q};
    diff_w = '0;
    unique case (state_q)
      S_LVL: begin
        diff_w = ext24(x_q) - ext24(pf_q);
        mul_a  = weight_op(alpha_q);
        mul_b  = diff_w[MUL_W-1:0];
      end
      S_TRM: begin
        diff_w = ext24(nl_q) - ext24(level_q) - ext24(trend_q);
        mul_a  = weight_op(beta_q);
        mul_b  = diff_w[MUL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= W_W'(32768);
      beta_q  <= W_W'(32768);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ALPHA: alpha_q <= cfg_wdata_i;
        CFG_BETA:  beta_q  <= cfg_wdata_i;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_EMPTY;
      x_q         <= '0;
      prev_q      <= '0;
      level_q     <= '0;
      trend_q     <= '0;
      pf_q        <= '0;
      err_q       <= '0;
      nl_q        <= '0;
      sum_q       <= '0;
      clip_q      <= 1'b0;
      fv_q        <= 1'b0;
      ev_q        <= 1'b0;
      out_valid_q <= 1'b0;
      fvo_q       <= 1'b0;
      fco_q       <= '0;
      evo_q       <= 1'b0;
      erro_q      <= '0;
      lvlo_q      <= '0;
      trdo_q      <= '0;
      sumo_q      <= '0;
      sato_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x_q    <= xs.val;
            prev_q <= xs.val;
            if (restart_i || phase_q == PH_EMPTY) begin
              level_q <= '0;
              trend_q <= '0;
              pf_q    <= '0;
              sum_q   <= '0;
              err_q   <= '0;
              phase_q <= PH_FIRST;
              clip_q  <= xs.clip;
              fv_q    <= 1'b0;
              ev_q    <= 1'b0;
              state_q <= S_OUT;
            end else if (phase_q == PH_FIRST) begin
              level_q <= xs.val;
              trend_q <= trs.val;
              err_q   <= '0;
              phase_q <= PH_RUN;
              clip_q  <= xs.clip | trs.clip;
              fv_q    <= 1'b1;
              ev_q    <= 1'b0;
              state_q <= S_PF;
            end else begin
              err_q   <= ers.val;
              clip_q  <= xs.clip | ers.clip;
              fv_q    <= 1'b1;
              ev_q    <= 1'b1;
              state_q <= S_SQ;
            end
          end
        end
        S_SQ: state_q <= S_LVL;
        S_LVL: begin
          if (sum_add[SUM_W]) begin
            sum_q  <= '1;
            clip_q <= 1'b1;
          end else begin
            sum_q <= sum_add[SUM_W-1:0];
          end
          state_q <= S_NLV;
        end
        S_NLV: begin
          nl_q    <= nls.val;
          clip_q  <= clip_q | nls.clip;
          state_q <= S_TRM;
        end
        S_TRM: state_q <= S_TRD;
        S_TRD: begin
          trend_q <= tns.val;
          level_q <= nl_q;
          clip_q  <= clip_q | tns.clip;
          state_q <= S_PF;
        end
        S_PF: begin
          pf_q    <= pfs.val;
          clip_q  <= clip_q | pfs.clip;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            fvo_q       <= fv_q;
            fco_q       <= fv_q ? pf_q : '0;
            evo_q       <= ev_q;
            erro_q      <= err_q;
            lvlo_q      <= level_q;
            trdo_q      <= trend_q;
            sumo_q      <= sum_q;
            sato_q      <= clip_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign forecast_valid_o = fvo_q;
  assign forecast_o       = fco_q;
  assign error_valid_o    = evo_q;
  assign error_o          = erro_q;
  assign level_o          = lvlo_q;
  assign trend_o          = trdo_q;
  assign sum_sq_error_o   = sumo_q;
  assign saturated_o      = sato_q;

endmodule

`default_nettype wire

FILE: verif/trend_smoothing_forecaster_core_tb.sv
// Self-checking testbench for the trend smoothing forecaster core.
`timescale 1ns / 1ps

module trend_smoothing_forecaster_core_tb;
  import tsf_pkg::*;

  localparam int     IDLE_LIMIT = 2000;
  localparam int     HOLD_OFF   = 300;
  localparam int     NUM_PHASES = 8;
  localparam longint SUM_CEIL   = 64'hFFFF_FFFF_FFFF;
  localparam longint Q_HI       = 8388607;
  localparam longint Q_LO       = -8388608;

  typedef struct {
    logic                  forecast_valid;
    logic signed [Q_W-1:0] forecast;
    logic                  error_valid;
    logic signed [Q_W-1:0] error;
    logic signed [Q_W-1:0] level;
    logic signed [Q_W-1:0] trend;
    logic [SUM_W-1:0]      sum_sq_error;
    logic                  saturated;
  } forecast_rec_t;

  class smoothing_scoreboard;
    logic [W_W-1:0] alpha = W_W'(32768);
    logic [W_W-1:0] beta  = W_W'(32768);
    logic [1:0]     phase = PH_EMPTY;
    longint         prev_sample = 0;
    longint         level = 0;
    longint         trend = 0;
    longint         forecast = 0;
    longint         err_sum = 0;
    bit             clipped;
    forecast_rec_t  expected_q[$];
    int             mismatches = 0;

    function void set_weight(logic idx, logic [W_W-1:0] value);
      if (idx == CFG_ALPHA) alpha = value;
      else beta = value;
    endfunction

    function longint clip(longint v);
      if (v > Q_HI) begin
        clipped = 1'b1;
        return Q_HI;
      end
      if (v < Q_LO) begin
        clipped = 1'b1;
        return Q_LO;
      end
      return v;
    endfunction

    // w*a + (1-w)*b in Q1.16, rounded to nearest with ties up
    function longint blend(logic [W_W-1:0] w, longint a, longint b);
      longint wa;
      wa = (w > ONE_Q16) ? longint'(ONE_Q16) : longint'(w);
      return (wa * a + (65536 - wa) * b + 32768) >>> 16;
    endfunction

    function void note_sample(logic restart, logic signed [SAMPLE_BITS-1:0] sample);
      forecast_rec_t r;
      longint x;
      longint e;
      longint sq;
      longint new_level;
      clipped = 1'b0;
      e = 0;
      r.forecast_valid = 1'b0;
      r.error_valid = 1'b0;
      x = clip(longint'(sample));
      if (restart || phase == PH_EMPTY) begin
        prev_sample = x;
        level = 0;
        trend = 0;
        forecast = 0;
        err_sum = 0;
        phase = PH_FIRST;
      end else if (phase == PH_FIRST) begin
        level = x;
        trend = clip(x - prev_sample);
        forecast = clip(level + trend);
        prev_sample = x;
        phase = PH_RUN;
        r.forecast_valid = 1'b1;
      end else begin
        e = clip(forecast - x);
        sq = e * e;
        if (sq > SUM_CEIL - err_sum) begin
          err_sum = SUM_CEIL;
          clipped = 1'b1;
        end else begin
          err_sum = err_sum + sq;
        end
        new_level = clip(blend(alpha, x, forecast));
        trend = clip(blend(beta, new_level - level, trend));
        level = new_level;
        forecast = clip(level + trend);
        prev_sample = x;
        r.forecast_valid = 1'b1;
        r.error_valid = 1'b1;
      end
      r.forecast = r.forecast_valid ? Q_W'(forecast) : '0;
      r.error = Q_W'(e);
      r.level = Q_W'(level);
      r.trend = Q_W'(trend);
      r.sum_sq_error = SUM_W'(err_sum);
      r.saturated = clipped;
      expected_q.push_back(r);
    endfunction

    function void compare(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(forecast_rec_t got);
      forecast_rec_t want;
      if (expected_q.size() == 0) begin
        $error("result transfer with no expected result");
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      compare("forecast_valid", want.forecast_valid, got.forecast_valid);
      compare("forecast", want.forecast, got.forecast);
      compare("error_valid", want.error_valid, got.error_valid);
      compare("error", want.error, got.error);
      compare("level", want.level, got.level);
      compare("trend", want.trend, got.trend);
      compare("sum_sq_error", want.sum_sq_error, got.sum_sq_error);
      compare("saturated", want.saturated, got.saturated);
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic                          cfg_index_i = CFG_ALPHA;
  logic [W_W-1:0]                cfg_wdata_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          restart_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          out_ready_i = 1'b0;
  logic                          in_ready_o;
  logic                          out_valid_o;
  logic                          forecast_valid_o;
  logic signed [Q_W-1:0]         forecast_o;
  logic                          error_valid_o;
  logic signed [Q_W-1:0]         error_o;
  logic signed [Q_W-1:0]         level_o;
  logic signed [Q_W-1:0]         trend_o;
  logic [SUM_W-1:0]              sum_sq_error_o;
  logic                          saturated_o;

  smoothing_scoreboard sb = new;
  int             idle_cycles = 0;
  bit             hold_off_req = 1'b0;
  int             sender_burst = 0;
  int             last_sample = 0;

  always #5 clk_i = ~clk_i;

  trend_smoothing_forecaster_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .restart_i        (restart_i),
    .sample_i         (sample_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .forecast_valid_o (forecast_valid_o),
    .forecast_o       (forecast_o),
    .error_valid_o    (error_valid_o),
    .error_o          (error_o),
    .level_o          (level_o),
    .trend_o          (trend_o),
    .sum_sq_error_o   (sum_sq_error_o),
    .saturated_o      (saturated_o)
  );

  always @(posedge clk_i) begin : monitor
    forecast_rec_t got;
    got.forecast_valid = forecast_valid_o;
    got.forecast = forecast_o;
    got.error_valid = error_valid_o;
    got.error = error_o;
    got.level = level_o;
    got.trend = trend_o;
    got.sum_sq_error = sum_sq_error_o;
    got.saturated = saturated_o;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_sample(restart_i, sample_i);
      if (out_valid_o && out_ready_i) sb.check_result(got);
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin : receiver
    int r;
    int burst;
    burst = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_ready_i <= 1'b1;
      end else begin
        r = $urandom_range(0, 199);
        if (r == 0) burst = 60;
        if (r < 130) begin
          out_ready_i <= 1'b1;
        end else begin
          out_ready_i <= 1'b0;
          if (r < 185) repeat ($urandom_range(1, 3)) @(posedge clk_i);
          else if (r < 196) repeat ($urandom_range(4, 12)) @(posedge clk_i);
          else repeat ($urandom_range(20, 50)) @(posedge clk_i);
          out_ready_i <= 1'b1;
        end
      end
    end
  end

  task automatic offer_sample(logic restart, logic signed [SAMPLE_BITS-1:0] sample);
    in_valid_i <= 1'b1;
    restart_i <= restart;
    sample_i <= sample;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic idle_sender();
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = 0;
    if (sender_burst > 0) sender_burst--;
    else if (r == 0) sender_burst = 50;
    else if (r >= 70 && r < 90) g = $urandom_range(1, 3);
    else if (r >= 90 && r < 98) g = $urandom_range(4, 10);
    else if (r >= 98) g = $urandom_range(20, 60);
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic feed(logic restart, logic signed [SAMPLE_BITS-1:0] sample);
    offer_sample(restart, sample);
    idle_sender();
  endtask

  // wait until every transfer has its result, then let the pipeline settle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_q.size() != 0);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic apply_weights(logic [W_W-1:0] a, logic [W_W-1:0] b);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_ALPHA;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_index_i <= CFG_BETA;
    cfg_wdata_i <= b;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_weight(CFG_ALPHA, a);
    sb.set_weight(CFG_BETA, b);
  endtask

  // series with rare restarts; samples drift, jump to extremes or take any value
  task automatic run_phase(int count, int restart_pm, int extreme_pct);
    int i;
    int m;
    int s;
    logic rs;
    for (i = 0; i < count; i++) begin
      rs = ($urandom_range(0, 999) < restart_pm);
      m = $urandom_range(0, 99);
      if (m < extreme_pct) begin
        s = $urandom_range(0, 1) ? 32767 : -32768;
      end else if (m < extreme_pct + 17) begin
        s = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        s = last_sample + int'($urandom_range(0, 1024)) - 512;
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
      end
      last_sample = s;
      offer_sample(rs, SAMPLE_BITS'(s));
      if (i != count - 1) idle_sender();
    end
  endtask

  initial begin : stimulus
    int p;
    logic [W_W-1:0] a;
    logic [W_W-1:0] b;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset weights: restart on the very first sample, extremes, restarts mid-series
    feed(1'b1, 16'sh7FFF);
    feed(1'b0, -16'sh8000);
    feed(1'b0, 16'sh7FFF);
    feed(1'b0, -16'sh8000);
    feed(1'b0, 16'sh0000);
    feed(1'b0, -16'sh0001);
    feed(1'b1, -16'sh8000);
    feed(1'b1, 16'sh7FFF);
    feed(1'b0, -16'sh8000);
    feed(1'b0, -16'sh8000);
    feed(1'b0, 16'sh7FFF);
    feed(1'b0, 16'sh0001);
    feed(1'b0, 16'sh0000);
    feed(1'b1, 16'sh0000);
    feed(1'b0, 16'sh0100);
    feed(1'b0, 16'sh0200);
    drain();

    for (p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin a = W_W'(0);      b = W_W'(65536);  end
        1: begin a = W_W'(65536);  b = W_W'(0);      end
        2: begin a = W_W'(131071); b = W_W'(131071); end
        3: begin a = W_W'(65537);  b = W_W'(1);      end
        default: begin
          a = ($urandom_range(0, 9) == 0) ? W_W'($urandom_range(65537, 131071))
                                          : W_W'($urandom_range(0, 65536));
          b = ($urandom_range(0, 9) == 0) ? W_W'($urandom_range(65537, 131071))
                                          : W_W'($urandom_range(0, 65536));
        end
      endcase
      apply_weights(a, b);
      if (p == 1) hold_off_req = 1'b1;
      // level that follows its own forecast with a constant trend runs into saturation of forecast and sum
      if (p == 0) run_phase(250, 7, 50);
      else run_phase(200, 40, 8);
      drain();
    end

    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
